// ----- hw/rtl/fpx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Field extractor package
// Shared widths, wire type codes and payload types of the varint field
// extractor.
// ----------------------------------------------------------------------------
package fpx_pkg;

   localparam int unsigned BYTE_WIDTH       = 8;
   localparam int unsigned GROUP_WIDTH      = 7;
   localparam int unsigned VALUE_WIDTH      = 28;
   localparam int unsigned FIELD_WIDTH      = 5;
   localparam int unsigned WIRE_WIDTH       = 3;
   localparam int unsigned COUNT_WIDTH      = 3;
   localparam int unsigned MAX_VARINT_BYTES = 4;
   localparam int unsigned FIXED32_BYTES    = 4;

   localparam logic [FIELD_WIDTH-1:0] TARGET_RESET = FIELD_WIDTH'(1);

   localparam logic [WIRE_WIDTH-1:0] WIRE_VARINT  = 3'd0;
   localparam logic [WIRE_WIDTH-1:0] WIRE_LENGTH  = 3'd2;
   localparam logic [WIRE_WIDTH-1:0] WIRE_FIXED32 = 3'd5;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] field_value;
   } rsp_payload_type;

   // Result produced by the parser for one processed byte.
   typedef struct packed {
      logic                   valid;
      logic [VALUE_WIDTH-1:0] value;
   } hit_type;

   // Byte held in the input register, handed to the parser.
   typedef struct packed {
      logic                  valid;
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  last_byte;
   } staged_type;

endpackage : fpx_pkg
`default_nettype wire

// ----- hw/rtl/fpx_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one payload; a transfer happens when valid
// and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface fpx_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface : fpx_stream_if
`default_nettype wire

// ----- hw/rtl/fpx_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Input register
// Captures one blob byte per transfer and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module fpx_in_stage
   import fpx_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   fpx_stream_if.sink  req_chan,
   input  wire logic   advance,
   output staged_type  staged
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [BYTE_WIDTH-1:0] byte_ff;
   logic                  last_ff;
   logic                  load;

   assign req_chan.ready = !valid_ff || advance;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         byte_ff <= req_chan.payload.data_byte;
         last_ff <= req_chan.payload.last_byte;
      end
   end

   assign staged.valid     = valid_ff;
   assign staged.data_byte = byte_ff;
   assign staged.last_byte = last_ff;

endmodule : fpx_in_stage
`default_nettype wire

// ----- hw/rtl/fpx_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wire format parser
// Walks tags, varints and skipped runs one byte per step and flags a
// completed nonzero varint of the target field.
// ----------------------------------------------------------------------------
module fpx_parser
   import fpx_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [BYTE_WIDTH-1:0]  data_byte,
   input  wire logic                   last_byte,
   input  wire logic [FIELD_WIDTH-1:0] target_field,
   output hit_type                     hit
);

   typedef enum logic [2:0] {
      MODE_TAG,
      MODE_VALUE,
      MODE_LENGTH,
      MODE_SKIP,
      MODE_HALT
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [VALUE_WIDTH-1:0] accum_ff, accum_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   match_ff, match_in;
   logic [VALUE_WIDTH-1:0] skip_ff, skip_in;

   logic [GROUP_WIDTH-1:0] group;
   logic [VALUE_WIDTH-1:0] group_shifted;
   logic [VALUE_WIDTH-1:0] accum_grown;
   logic [COUNT_WIDTH-1:0] count_grown;
   logic                   group_done;
   logic [VALUE_WIDTH-1:0] skip_less;
   logic [WIRE_WIDTH-1:0]  wire_type;

   assign group     = data_byte[GROUP_WIDTH-1:0];
   assign wire_type = data_byte[WIRE_WIDTH-1:0];

   // Place the 7-bit group at its position; the fourth group fills the
   // top of the 28-bit value exactly.
   always_comb begin
      case (count_ff)
         3'd0:    group_shifted = VALUE_WIDTH'(group);
         3'd1:    group_shifted = VALUE_WIDTH'(group) << GROUP_WIDTH;
         3'd2:    group_shifted = VALUE_WIDTH'(group) << (2 * GROUP_WIDTH);
         3'd3:    group_shifted = VALUE_WIDTH'(group) << (3 * GROUP_WIDTH);
         default: group_shifted = '0;
      endcase
   end

   always_comb begin
      if (count_ff < COUNT_WIDTH'(MAX_VARINT_BYTES)) begin
         accum_grown = accum_ff | group_shifted;
         count_grown = count_ff + COUNT_WIDTH'(1);
      end else begin
         accum_grown = accum_ff;
         count_grown = count_ff;
      end
      group_done = !data_byte[BYTE_WIDTH-1]
                   || (count_grown >= COUNT_WIDTH'(MAX_VARINT_BYTES));
      skip_less  = (skip_ff != '0) ? skip_ff - VALUE_WIDTH'(1) : skip_ff;
   end

   always_comb begin
      mode_in   = mode_ff;
      accum_in  = accum_ff;
      count_in  = count_ff;
      match_in  = match_ff;
      skip_in   = skip_ff;
      hit.valid = 1'b0;
      hit.value = accum_grown;

      unique case (mode_ff)
         MODE_TAG: begin
            match_in = (data_byte[BYTE_WIDTH-1:WIRE_WIDTH] == target_field);
            accum_in = '0;
            count_in = '0;
            if (wire_type == WIRE_VARINT) begin
               mode_in = MODE_VALUE;
            end else if (wire_type == WIRE_FIXED32) begin
               skip_in = VALUE_WIDTH'(FIXED32_BYTES);
               mode_in = MODE_SKIP;
            end else if (wire_type == WIRE_LENGTH) begin
               mode_in = MODE_LENGTH;
            end else begin
               mode_in = MODE_HALT;
            end
         end
         MODE_VALUE: begin
            accum_in = accum_grown;
            count_in = count_grown;
            if (group_done || last_byte) begin
               hit.valid = match_ff && (accum_grown != '0);
               mode_in   = MODE_TAG;
            end
         end
         MODE_LENGTH: begin
            accum_in = accum_grown;
            count_in = count_grown;
            if (group_done) begin
               if (accum_grown == '0) begin
                  mode_in = MODE_TAG;
               end else begin
                  skip_in = accum_grown;
                  mode_in = MODE_SKIP;
               end
            end
         end
         MODE_SKIP: begin
            skip_in = skip_less;
            if (skip_less == '0) begin
               mode_in = MODE_TAG;
            end
         end
         MODE_HALT: begin
            mode_in = MODE_HALT;
         end
         default: begin
            mode_in = MODE_TAG;
         end
      endcase

      // The end of a blob returns every piece of parse state to reset.
      if (last_byte) begin
         mode_in  = MODE_TAG;
         accum_in = '0;
         count_in = '0;
         match_in = 1'b0;
         skip_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TAG;
         accum_ff <= '0;
         count_ff <= '0;
         match_ff <= 1'b0;
         skip_ff  <= '0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
         match_ff <= match_in;
         skip_ff  <= skip_in;
      end
   end

endmodule : fpx_parser
`default_nettype wire

// ----- hw/rtl/fpx_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result register
// Holds one extracted field value until the downstream side takes the
// transfer.
// ----------------------------------------------------------------------------
module fpx_out_stage
   import fpx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire hit_type hit,
   output logic         take,
   fpx_stream_if.source rsp_chan
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic                   load;

   // The register can accept a new result once its current one leaves.
   assign take     = !valid_ff || rsp_chan.ready;
   assign load     = advance && hit.valid;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         value_ff <= hit.value;
      end
   end

   assign rsp_chan.valid               = valid_ff;
   assign rsp_chan.payload.field_value = value_ff;

endmodule : fpx_out_stage
`default_nettype wire

// ----- hw/rtl/protobuf_varint_field_extractor_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A completing byte is held in the input register, parsed, and its result registered.
// Throughput: one blob byte per cycle; the parser state update is a single step.
// Backpressure on the result channel stalls the input register and parser together.
// Reset is synchronous and active high; it returns the parser to tag state and the
// target field register to 1.
// ----------------------------------------------------------------------------
// Varint field extractor
// Scans a protobuf-style blob byte by byte and reports nonzero varint values
// of the configured field number.
// ----------------------------------------------------------------------------
module protobuf_varint_field_extractor_top
   import fpx_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   fpx_stream_if.sink                  req_chan,
   fpx_stream_if.source                rsp_chan,
   input  wire logic                   csr_write_enable,
   input  wire logic [FIELD_WIDTH-1:0] csr_write_data
);

   logic [FIELD_WIDTH-1:0] target_ff;
   staged_type             staged;
   hit_type                hit;
   logic                   take;
   logic                   advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
      end else if (csr_write_enable) begin
         target_ff <= csr_write_data;
      end
   end

   // A staged byte is parsed once the result register has room for its result.
   assign advance = staged.valid && take;

   fpx_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .staged   (staged)
   );

   fpx_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .data_byte    (staged.data_byte),
      .last_byte    (staged.last_byte),
      .target_field (target_ff),
      .hit          (hit)
   );

   fpx_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .hit      (hit),
      .take     (take),
      .rsp_chan (rsp_chan)
   );

endmodule : protobuf_varint_field_extractor_top
`default_nettype wire
